@@ rtl/egbr_pkg.sv @@
package egbr_pkg;

    // Default ring size in bytes
    localparam int DEF_BUFFER_BYTES = 32;

    // Request opcodes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_PUSH  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_UE    = 3'd3;
    localparam logic [2:0] OP_SE    = 3'd4;
    localparam logic [2:0] OP_SKIP  = 3'd5;

    // Longest fixed read and widest leading-zero scan
    localparam int PEEK_MAX = 32;
    // Longest bit run a single request may consume (ue/se code with 31 leading zeros)
    localparam int NEED_BITS = 2 * PEEK_MAX - 1;
    // Bit window ahead of the byte RAM
    localparam int WIN_BITS = 72;

    // Queue depths between the parts
    localparam int CMD_DEPTH   = 2;
    localparam int RSP_DEPTH   = 4;
    localparam int RSP_LEVEL_W = $clog2(RSP_DEPTH + 1);

    // Classified request kinds
    typedef enum logic [2:0] {
        K_NONE,
        K_START,
        K_PUSH,
        K_READ,
        K_UE,
        K_SE,
        K_SKIP
    } kind_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byte_value;
        logic [5:0] bit_count;
    } req_t;

    typedef struct packed {
        logic signed [32:0] value;
        logic               error;
        logic [8:0]         bits_left;
    } rsp_t;

    typedef struct packed {
        kind_t      kind;
        logic       too_long;
        logic [7:0] byte_value;
        logic [5:0] bit_count;
    } cmd_t;

endpackage

@@ rtl/egbr_ram.sv @@
module egbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/egbr_fifo.sv @@
module egbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = store_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

@@ rtl/egbr_front.sv @@
module egbr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  egbr_pkg::req_t req,
    output egbr_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop
);

    import egbr_pkg::*;

    cmd_t                  cls;
    logic [$bits(cmd_t)-1:0] cmd_bits;
    logic                  q_full;
    logic                  q_empty;

    // Classify the request
    always_comb
    begin
        cls.byte_value = req.byte_value;
        cls.bit_count  = req.bit_count;
        cls.too_long   = (req.bit_count > 6'(PEEK_MAX));
        unique case (req.op)
            OP_START: cls.kind = K_START;
            OP_PUSH:  cls.kind = K_PUSH;
            OP_READ:  cls.kind = K_READ;
            OP_UE:    cls.kind = K_UE;
            OP_SE:    cls.kind = K_SE;
            OP_SKIP:  cls.kind = K_SKIP;
            default:  cls.kind = K_NONE;
        endcase
    end

    // Hold classified requests until the back end takes them
    egbr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !q_full),
        .wr_data (cls),
        .rd_en   (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (q_empty),
        .full    (q_full),
        .count   ()
    );

    assign full      = q_full;
    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !q_empty;

endmodule

@@ rtl/egbr_back.sv @@
module egbr_back #(
    parameter int BUFFER_BYTES = egbr_pkg::DEF_BUFFER_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  egbr_pkg::cmd_t                    cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    input  logic [egbr_pkg::RSP_LEVEL_W-1:0]  rsp_level,
    output logic                              rsp_push,
    output egbr_pkg::rsp_t                    rsp
);

    import egbr_pkg::*;

    localparam int RING_BITS  = BUFFER_BYTES * 8;
    localparam int HW         = $clog2(RING_BITS + 8);
    localparam int AW         = $clog2(BUFFER_BYTES);
    localparam int CW         = $clog2(BUFFER_BYTES + 1);
    localparam int CNTW       = $clog2(WIN_BITS + 1);
    localparam int LZW        = $clog2(PEEK_MAX + 1);
    localparam int REFILL_MAX = WIN_BITS - 8;

    // Count leading zeros of the window head; all zero gives PEEK_MAX
    function automatic logic [LZW-1:0] lead_zeros(input logic [PEEK_MAX-1:0] v);
        logic [LZW-1:0] n;
        n = LZW'(PEEK_MAX);
        for (int i = 0; i < PEEK_MAX; i++)
        begin
            if (v[i])
            begin
                n = LZW'(PEEK_MAX - 1 - i);
            end
        end
        return n;
    endfunction

    // Architectural state
    logic [HW-1:0]       held_reg, held_next;
    logic [2:0]          off_reg, off_next;
    logic                err_reg, err_next;
    logic [5:0]          pend_reg, pend_next;

    // Bit window, MSB is the next unread bit; bits below the count are zero
    logic [WIN_BITS-1:0] win_reg, win_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;

    // Byte RAM queue behind the window
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       ram_cnt_reg, ram_cnt_next;
    logic                inflight_reg;
    logic                ram_we;
    logic                issue;
    logic [7:0]          ram_rdata;

    // Result stage
    logic                s2_valid_reg;
    kind_t               s2_kind_reg;
    logic                s2_ok_reg;
    logic [NEED_BITS-1:0] s2_bits_reg;
    logic [LZW-1:0]      s2_lz_reg;
    logic [5:0]          s2_n_reg;
    logic                s2_err_reg;
    logic [8:0]          s2_left_reg;

    // Execute-stage signals
    logic                needs_win;
    logic                win_ok;
    logic                room;
    logic                exec;
    logic [LZW-1:0]      lz;
    logic [LZW-1:0]      limit;
    logic [CNTW-1:0]     len;
    logic [HW-1:0]       n_ext;
    logic                eg_ok;
    logic                rd_ok;
    logic                sk_ok;
    logic                buf_full;
    logic                direct_ok;
    logic [HW:0]         held8;
    logic [HW:0]         drop;
    logic                ok;
    logic                flush;
    logic                direct;
    logic [CNTW-1:0]     shamt;
    logic [WIN_BITS-1:0] win_a, win_b;
    logic [CNTW-1:0]     cnt_a, cnt_b;
    logic                land;

    // Decide whether the window must be topped up first
    always_comb
    begin
        unique case (cmd.kind) inside
            K_READ, K_UE, K_SE, K_SKIP: needs_win = 1'b1;
            default:                    needs_win = 1'b0;
        endcase
    end

    assign win_ok = (cnt_reg >= CNTW'(NEED_BITS)) || (HW'(cnt_reg) == held_reg);
    assign room   = (({1'b0, rsp_level} + (RSP_LEVEL_W + 1)'(s2_valid_reg))
                    < (RSP_LEVEL_W + 1)'(RSP_DEPTH));
    assign exec    = cmd_valid && room && (!needs_win || win_ok);
    assign cmd_pop = exec;

    // Classify the head of the window
    assign lz    = lead_zeros(win_reg[WIN_BITS-1 -: PEEK_MAX]);
    assign limit = (held_reg < HW'(PEEK_MAX)) ? LZW'(held_reg) : LZW'(PEEK_MAX);
    assign len   = CNTW'({lz, 1'b0}) + CNTW'(1);
    assign n_ext = HW'(cmd.bit_count);
    assign eg_ok = (held_reg != '0) && (lz < limit) && (HW'(len) <= held_reg);
    assign rd_ok = !cmd.too_long && (n_ext <= held_reg);
    assign sk_ok = (held_reg != '0) && (n_ext <= held_reg);
    assign buf_full  = ((HW + 1)'(off_reg) + (HW + 1)'(held_reg)) >= (HW + 1)'(RING_BITS);
    assign direct_ok = (ram_cnt_reg == '0) && !inflight_reg && (cnt_reg <= CNTW'(REFILL_MAX));
    assign held8     = (HW + 1)'(held_reg) + (HW + 1)'(8);
    assign drop      = ((HW + 1)'(pend_reg) < held8) ? (HW + 1)'(pend_reg) : held8;

    // Carry out the request
    always_comb
    begin
        held_next = held_reg;
        off_next  = off_reg;
        err_next  = err_reg;
        pend_next = pend_reg;
        ok        = 1'b0;
        flush     = 1'b0;
        direct    = 1'b0;
        ram_we    = 1'b0;
        shamt     = '0;
        if (exec)
        begin
            case (cmd.kind) inside
                K_START:
                begin
                    flush     = 1'b1;
                    held_next = '0;
                    off_next  = '0;
                    err_next  = 1'b0;
                    pend_next = cmd.bit_count;
                end
                K_PUSH:
                begin
                    if (buf_full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        direct    = direct_ok;
                        ram_we    = !direct_ok;
                        held_next = HW'(held8 - drop);
                        off_next  = off_reg + drop[2:0];
                        pend_next = pend_reg - 6'(drop);
                        shamt     = CNTW'(drop);
                    end
                end
                K_READ:
                begin
                    if (rd_ok)
                    begin
                        ok = 1'b1;
                        shamt = CNTW'(cmd.bit_count);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                K_UE, K_SE:
                begin
                    if (eg_ok)
                    begin
                        ok = 1'b1;
                        shamt = len;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                K_SKIP:
                begin
                    if (sk_ok)
                    begin
                        shamt = CNTW'(cmd.bit_count);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.kind != K_PUSH && cmd.kind != K_START)
            begin
                held_next = held_reg - HW'(shamt);
                off_next  = off_reg + shamt[2:0];
            end
        end
    end

    // Insert a direct byte, drop consumed bits, then append a byte from the RAM
    assign land  = inflight_reg && !flush;
    assign win_a = direct ? (win_reg | ({cmd.byte_value, {(WIN_BITS - 8){1'b0}}} >> cnt_reg))
                          : win_reg;
    assign cnt_a = direct ? cnt_reg + CNTW'(8) : cnt_reg;
    assign win_b = win_a << shamt;
    assign cnt_b = cnt_a - shamt;

    always_comb
    begin
        if (flush)
        begin
            win_next = '0;
            cnt_next = '0;
        end
        else if (land)
        begin
            win_next = win_b | ({ram_rdata, {(WIN_BITS - 8){1'b0}}} >> cnt_b);
            cnt_next = cnt_b + CNTW'(8);
        end
        else
        begin
            win_next = win_b;
            cnt_next = cnt_b;
        end
    end

    // Refill the window one byte a cycle while it has room
    assign issue = !flush && (ram_cnt_reg != '0)
                   && ((cnt_reg + (inflight_reg ? CNTW'(8) : CNTW'(0))) <= CNTW'(REFILL_MAX));

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        ram_cnt_next = ram_cnt_reg;
        if (flush)
        begin
            wr_ptr_next  = '0;
            rd_ptr_next  = '0;
            ram_cnt_next = '0;
        end
        else
        begin
            if (ram_we)
            begin
                wr_ptr_next = (wr_ptr_reg == AW'(BUFFER_BYTES - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (issue)
            begin
                rd_ptr_next = (rd_ptr_reg == AW'(BUFFER_BYTES - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            ram_cnt_next = ram_cnt_reg + CW'(ram_we) - CW'(issue);
        end
    end

    egbr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_byte_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (cmd.byte_value),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            off_reg      <= '0;
            err_reg      <= 1'b0;
            pend_reg     <= '0;
            win_reg      <= '0;
            cnt_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            ram_cnt_reg  <= '0;
            inflight_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg     <= held_next;
            off_reg      <= off_next;
            err_reg      <= err_next;
            pend_reg     <= pend_next;
            win_reg      <= win_next;
            cnt_reg      <= cnt_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            ram_cnt_reg  <= ram_cnt_next;
            inflight_reg <= issue;
            s2_valid_reg <= exec;
        end
    end

    // Capture what the result stage needs
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            s2_kind_reg <= cmd.kind;
            s2_ok_reg   <= ok;
            s2_bits_reg <= win_reg[WIN_BITS-1 -: NEED_BITS];
            s2_lz_reg   <= lz;
            s2_n_reg    <= cmd.bit_count;
            s2_err_reg  <= err_next;
            s2_left_reg <= 9'(held_next);
        end
    end

    // Form the value: fixed field, or codeword minus one, mapped to signed for se
    logic [PEEK_MAX:0]    rd_val;
    logic [NEED_BITS-1:0] cw;
    logic [32:0]          cw33;
    logic [32:0]          mag;
    logic [32:0]          val;

    assign rd_val = {1'b0, s2_bits_reg[NEED_BITS-1 -: PEEK_MAX]} >> (6'(PEEK_MAX) - s2_n_reg);
    assign cw     = s2_bits_reg >> (6'(NEED_BITS - 1) - 6'({s2_lz_reg, 1'b0}));
    assign cw33   = cw[32:0];
    assign mag    = {1'b0, cw33[32:1]};

    always_comb
    begin
        val = '0;
        if (s2_ok_reg)
        begin
            case (s2_kind_reg)
                K_READ:  val = 33'(rd_val);
                K_UE:    val = cw33 - 33'(1);
                K_SE:    val = cw33[0] ? (33'(0) - mag) : mag;
                default: val = '0;
            endcase
        end
    end

    assign rsp_push      = s2_valid_reg;
    assign rsp.value     = $signed(val);
    assign rsp.error     = s2_err_reg;
    assign rsp.bits_left = s2_left_reg;

`ifndef SYNTHESIS
    a_held_split: assert property (@(posedge clk) disable iff (!rst_n)
        (HW + 2)'(held_reg) == (HW + 2)'(cnt_reg)
            + (((HW + 2)'(ram_cnt_reg) + (HW + 2)'(inflight_reg)) << 3))
        else $error("held bits disagree with window and byte queue");

    a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(WIN_BITS))
        else $error("bit window overrun");

    a_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> (held_reg == '0))
        else $error("start skip pending while bits are held");

    a_ram_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_cnt_reg <= CW'(BUFFER_BYTES))
        else $error("byte queue overrun");
`endif

endmodule

@@ rtl/exp_golomb_bit_reader_core.sv @@
// Bit reader for H.264 syntax elements: byte pushes, fixed reads up to 32 bits,
// ue/se Exp-Golomb decodes and skips, one result per request in request order.
// Requests are taken one per cycle when nothing stalls, and each result goes
// through the command queue, the result stage and the result queue. Bytes go
// through a byte RAM of BUFFER_BYTES entries into a 72-bit window that feeds
// the leading-zero count and the field extract; the RAM has one read port and
// refills the window one byte per cycle while the window has room. A read,
// decode or skip waits while the window holds fewer than 63 bits and more bits
// sit in the RAM; pushes, starts and requests served from a full window go at
// one per cycle while the result queue has room. Unwritten RAM entries are
// never read, so no clearing pass follows reset.
module exp_golomb_bit_reader_core #(
    parameter int BUFFER_BYTES = egbr_pkg::DEF_BUFFER_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  egbr_pkg::req_t req,
    input  logic           pop,
    output logic           empty,
    output egbr_pkg::rsp_t rsp
);

    import egbr_pkg::*;

    cmd_t                    cmd;
    logic                    cmd_valid;
    logic                    cmd_pop;
    logic                    rsp_push;
    rsp_t                    rsp_in;
    logic [RSP_LEVEL_W-1:0]  rsp_level;
    logic [$bits(rsp_t)-1:0] rsp_bits;
    logic                    rsp_full;

    // Accept and classify requests
    egbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Execute against the bit buffer
    egbr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp_level (rsp_level),
        .rsp_push  (rsp_push),
        .rsp       (rsp_in)
    );

    // Hold results until popped
    egbr_fifo #(
        .WIDTH ($bits(rsp_t)),
        .DEPTH (RSP_DEPTH)
    ) u_rsp_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rsp_push),
        .wr_data (rsp_in),
        .rd_en   (pop && !empty),
        .rd_data (rsp_bits),
        .empty   (empty),
        .full    (rsp_full),
        .count   (rsp_level)
    );

    assign rsp = rsp_t'(rsp_bits);

`ifndef SYNTHESIS
    a_rsp_space: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |-> (!rsp_full || (pop && !empty)))
        else $error("result written into a full queue");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import egbr_pkg::*;

    localparam int RING_BYTES = DEF_BUFFER_BYTES;
    localparam int RING_BIT_W = $clog2(RING_BYTES * 8);
    localparam int HELD_W     = $clog2(RING_BYTES * 8 + 1);
    localparam int RANDOM_OPS = 1650;
    localparam int NUM_PHASES = 4;
    localparam int DRAIN_CYCLES = 20;

    // Opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    req_t req = '0;
    logic full;
    logic empty;
    rsp_t rsp;

    req_t pending_reqs[$];
    rsp_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ops_queued = 0;
    int fail_count = 0;
    int result_index = 0;

    // Shadow copy of the reader state
    logic [7:0]            shadow_bytes [RING_BYTES];
    logic [RING_BIT_W-1:0] rd_bitpos = '0;
    logic [4:0]            wr_slot = '0;
    logic [HELD_W-1:0]     held_bits = '0;
    logic [5:0]            skip_owed = '0;
    logic                  sticky_err = 1'b0;

    exp_golomb_bit_reader_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .pop   (pop),
        .empty (empty),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    // Bit at an offset from the read position, MSB first within each byte
    function automatic logic ring_bit(input int ofs);
        logic [RING_BIT_W-1:0] p;
        p = rd_bitpos + RING_BIT_W'(ofs);
        return shadow_bytes[p[RING_BIT_W-1:3]][~p[2:0]];
    endfunction

    function automatic logic [63:0] peek_field(input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v = {v[62:0], ring_bit(i)};
        return v;
    endfunction

    function automatic void eat_bits(input int n);
        rd_bitpos = rd_bitpos + RING_BIT_W'(n);
        held_bits = held_bits - HELD_W'(n);
    endfunction

    // Exp-Golomb code number; flags an error and consumes nothing on failure
    function automatic logic golomb_code(output logic [32:0] code);
        int limit;
        int lz;
        logic [63:0] info;
        code = '0;
        if (held_bits == 0)
        begin
            sticky_err = 1'b1;
            return 1'b0;
        end
        limit = (held_bits < PEEK_MAX) ? int'(held_bits) : PEEK_MAX;
        lz = 0;
        while (lz < limit && ring_bit(lz) == 1'b0)
            lz++;
        if (lz == limit || 2 * lz + 1 > int'(held_bits))
        begin
            sticky_err = 1'b1;
            return 1'b0;
        end
        eat_bits(lz + 1);
        info = peek_field(lz);
        code = (33'd1 << lz) - 33'd1 + info[32:0];
        eat_bits(lz);
        return 1'b1;
    endfunction

    // Apply one accepted request and queue the response it should produce
    function automatic void decode_request(input req_t r);
        rsp_t want;
        logic [32:0] code;
        logic [32:0] mag;
        logic [63:0] bits_seen;
        int drop;
        want = '0;
        case (r.op)
            OP_START:
            begin
                rd_bitpos = '0;
                wr_slot = '0;
                held_bits = '0;
                sticky_err = 1'b0;
                skip_owed = r.bit_count;
            end
            OP_PUSH:
            begin
                if (int'(rd_bitpos[2:0]) + int'(held_bits) >= RING_BYTES * 8)
                    sticky_err = 1'b1;
                else
                begin
                    shadow_bytes[wr_slot] = r.byte_value;
                    wr_slot = wr_slot + 5'd1;
                    held_bits = held_bits + HELD_W'(8);
                    drop = (skip_owed < held_bits) ? int'(skip_owed) : int'(held_bits);
                    eat_bits(drop);
                    skip_owed = skip_owed - 6'(drop);
                end
            end
            OP_READ:
            begin
                if (r.bit_count <= PEEK_MAX && held_bits >= r.bit_count)
                begin
                    bits_seen = peek_field(int'(r.bit_count));
                    want.value = bits_seen[32:0];
                    eat_bits(r.bit_count);
                end
                else
                    sticky_err = 1'b1;
            end
            OP_UE:
            begin
                if (golomb_code(code))
                    want.value = code;
            end
            OP_SE:
            begin
                if (golomb_code(code))
                begin
                    mag = (code + 33'd1) >> 1;
                    want.value = code[0] ? mag : -mag;
                end
            end
            OP_SKIP:
            begin
                if (held_bits == 0 || r.bit_count > held_bits)
                    sticky_err = 1'b1;
                else
                    eat_bits(r.bit_count);
            end
            default:
            begin
            end
        endcase
        want.error = sticky_err;
        want.bits_left = held_bits;
        expected_results.push_back(want);
    endfunction

    // Request driver: hold a request until accepted, then load the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (push && !full)
                decode_request(req);
            if (!push || !full)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    req <= pending_reqs.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Response monitor: compare each popped response with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response %0d: value %h error %b bits_left %0d",
                                 result_index, rsp.value, rsp.error, rsp.bits_left);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.value !== want.value || rsp.error !== want.error
                        || rsp.bits_left !== want.bits_left)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("response %0d (exp/got): value %h/%h %s %b/%b %s %0d/%0d",
                                     result_index, want.value, rsp.value, "error",
                                     want.error, rsp.error, "bits_left",
                                     want.bits_left, rsp.bits_left);
                    end
                end
                result_index++;
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic add_req(input logic [2:0] op, input logic [7:0] value, input logic [5:0] count);
        req_t r;
        r.op = op;
        r.byte_value = value;
        r.bit_count = count;
        pending_reqs.push_back(r);
        if (op != OP_SPARE_6 && op != OP_SPARE_7)
            ops_queued++;
    endtask

    // Zero bytes are common so that long codes and all-zero windows show up
    function automatic logic [7:0] data_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    function automatic logic [5:0] read_len();
        return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 32));
    endfunction

    // One stream: start, optional fill up to or past overflow, then mixed requests
    task automatic add_stream();
        int len;
        int roll;
        add_req(OP_START, 8'($urandom),
                ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'd0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(28, 36)) add_req(OP_PUSH, data_byte(), 6'($urandom));
        len = $urandom_range(10, 60);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 42)
                add_req(OP_PUSH, data_byte(), 6'($urandom));
            else if (roll < 56)
                add_req(OP_READ, 8'($urandom), read_len());
            else if (roll < 70)
                add_req(OP_UE, 8'($urandom), 6'($urandom));
            else if (roll < 84)
                add_req(OP_SE, 8'($urandom), 6'($urandom));
            else if (roll < 95)
                add_req(OP_SKIP, 8'($urandom), ($urandom_range(0, 3) == 0) ?
                        6'($urandom_range(0, 63)) : 6'($urandom_range(0, 20)));
            else if (roll < 97)
                add_req(($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7,
                        8'($urandom), 6'($urandom));
            else
                add_req(OP_START, 8'($urandom), 6'($urandom_range(0, 7)));
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || push || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int idle_pct [NUM_PHASES];
        int stall_pct [NUM_PHASES];
        idle_pct = '{0, 77, 0, 31};
        stall_pct = '{0, 0, 77, 31};

        // Directed: empty-buffer cases, start index, zero window, long code, se sign
        add_req(OP_START, 8'h00, 6'd0);
        add_req(OP_READ, 8'hFF, 6'd0);
        add_req(OP_UE, 8'h00, 6'd0);
        add_req(OP_SKIP, 8'h00, 6'd0);
        add_req(OP_START, 8'h00, 6'd3);
        add_req(OP_PUSH, 8'hFF, 6'd0);
        repeat (4) add_req(OP_PUSH, 8'h00, 6'd63);
        add_req(OP_READ, 8'h00, 6'd5);
        add_req(OP_UE, 8'h00, 6'd0);
        add_req(OP_READ, 8'h00, 6'd33);
        add_req(OP_START, 8'h00, 6'd0);
        add_req(OP_PUSH, 8'h00, 6'd0);
        add_req(OP_PUSH, 8'h01, 6'd0);
        add_req(OP_UE, 8'h00, 6'd0);
        add_req(OP_PUSH, 8'hFF, 6'd0);
        add_req(OP_PUSH, 8'hFF, 6'd0);
        add_req(OP_UE, 8'h00, 6'd0);
        add_req(OP_SE, 8'h00, 6'd0);
        add_req(OP_START, 8'h00, 6'd0);
        add_req(OP_PUSH, 8'h60, 6'd0);
        add_req(OP_SE, 8'h00, 6'd0);
        add_req(OP_SKIP, 8'h00, 6'd5);
        add_req(OP_SKIP, 8'h00, 6'd1);
        add_req(OP_SPARE_6, 8'hFF, 6'd63);
        add_req(OP_START, 8'hFF, 6'd63);
        add_req(OP_PUSH, 8'hFF, 6'd0);

        // Hold reset, then release at a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Random streams under each idle/stall mix
        ops_queued = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            send_idle_pct = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            while (ops_queued < RANDOM_OPS * (ph + 1) / NUM_PHASES)
                add_stream();
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
